/* hw/rtl/report_ring_with_dedup_unit_defines.svh */
// Assertion macros for the report ring with duplicate filter.
// Included by the checker module; depends on nothing else.
`ifndef REPORT_RING_WITH_DEDUP_UNIT_DEFINES_SVH
`define REPORT_RING_WITH_DEDUP_UNIT_DEFINES_SVH

// Same-cycle implication, held off while reset is asserted.
`define RRD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rrd assertion failed");

// Next-cycle implication, held off while reset is asserted.
`define RRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rrd assertion failed");

`endif

/* hw/rtl/rrd_pkg.sv */
// Shared types and constants of the report ring with duplicate filter.
// No dependencies; used by all rrd modules and the top level.
`default_nettype none

package rrd_pkg;

    localparam int RING_DEPTH_DEF       = 16;
    localparam int MAX_REPORT_BYTES_DEF = 8;

    localparam int REPORT_W   = 64;
    localparam int SERIAL_W   = 8;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 72;  // status + report, padded to bytes
    localparam int M_TDATA_W  = 80;  // result fields, padded to bytes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_BYTES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEDUP_ENABLE = 2'd1;

    // operation codes
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // transfer status codes
    localparam logic [STATUS_W-1:0] XFER_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] XFER_LINK_RESET = 2'd1;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch input item and read the ring entry
        logic commit;   // update ring state and load the result register
    } t_cmd;

endpackage

`default_nettype wire

/* hw/rtl/report_ring_with_dedup_unit.sv */
// Report ring with duplicate filter and drop-oldest overflow.
//
// Input stream (s_axis_*): one operation per transfer. tuser[0] selects push
// or pop; tdata carries the transfer status and up to 8 report bytes.
// Output stream (m_axis_*): exactly one result per input transfer, in order.
// Configuration channel (cfg_*): report size and duplicate filter enable,
// always ready; write only while no operation is outstanding.
// Each operation has a capture step, which latches the item and reads the
// ring entry (newest for a push, oldest for a pop) through the single
// registered memory read port, and a commit step, which updates the ring
// and loads the result register. The commit waits while a held result is
// not taken; a new item is accepted only after the previous one commits.
// When the receiver stalls the result is held in the output register; the
// next item may be accepted meanwhile, but it finishes only once the held
// result is taken. Reset (synchronous, active low) empties the ring, zeroes
// the serial counter and overflow flag, and restores the configuration
// defaults; no memory clearing pass is needed.
// Depends on rrd_pkg, rrd_ctrl and rrd_datapath.
`default_nettype none

module report_ring_with_dedup_unit #(
    parameter int RING_DEPTH       = rrd_pkg::RING_DEPTH_DEF,
    parameter int MAX_REPORT_BYTES = rrd_pkg::MAX_REPORT_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // [1:0] xfer_status, [65:2] report_data, [71:66] zero
    input  wire logic [rrd_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] func
    input  wire logic                            s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // [0] stored, [1] duplicate, [2] dropped_oldest, [3] resubmit,
    // [4] pop_valid, [68:5] out_report, [76:69] out_serial,
    // [77] overflow_seen, [79:78] zero
    output logic      [rrd_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [rrd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [rrd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    rrd_pkg::t_cmd cmd;

    assign cfg_ready = 1'b1;

    rrd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    rrd_datapath #(
        .RING_DEPTH       (RING_DEPTH),
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (s_axis_tuser),
        .i_status    (s_axis_tdata[1:0]),
        .i_data      (s_axis_tdata[65:2]),
        .i_cfg_we    (cfg_valid),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_result    (m_axis_tdata)
    );

endmodule

`default_nettype wire

/* hw/rtl/rrd_ctrl.sv */
// Controller of the report ring: two-state sequencer and result valid flag.
// Depends on rrd_pkg.
`default_nettype none

module rrd_ctrl (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output rrd_pkg::t_cmd    o_cmd
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.capture = (r_state == S_IDLE) && i_in_valid;
        // result register must be free or emptying this cycle
        o_cmd.commit  = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);
        n_state       = r_state;
        n_out_valid   = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.capture) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (o_cmd.commit) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rrd_datapath.sv */
// Datapath of the report ring: ring memories, indexes, duplicate compare,
// configuration registers and result register. Depends on rrd_pkg.
`default_nettype none

module rrd_datapath #(
    parameter int RING_DEPTH       = rrd_pkg::RING_DEPTH_DEF,
    parameter int MAX_REPORT_BYTES = rrd_pkg::MAX_REPORT_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire rrd_pkg::t_cmd                   i_cmd,
    input  wire logic                            i_func,
    input  wire logic [rrd_pkg::STATUS_W-1:0]    i_status,
    input  wire logic [rrd_pkg::REPORT_W-1:0]    i_data,
    input  wire logic                            i_cfg_we,
    input  wire logic [rrd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rrd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic      [rrd_pkg::M_TDATA_W-1:0]   o_result
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int RW    = MAX_REPORT_BYTES * 8;

    logic [RW-1:0]                 r_report_mem [RING_DEPTH];
    logic [rrd_pkg::SERIAL_W-1:0]  r_serial_mem [RING_DEPTH];

    logic                              r_func;
    logic [rrd_pkg::STATUS_W-1:0]      r_status;
    logic [RW-1:0]                     r_data;
    logic [RW-1:0]                     r_rd_report;
    logic [rrd_pkg::SERIAL_W-1:0]      r_rd_serial;

    logic [IDX_W-1:0]                  r_wr_idx, n_wr_idx;
    logic [IDX_W-1:0]                  r_rd_idx, n_rd_idx;
    logic [rrd_pkg::SERIAL_W-1:0]      r_serial, n_serial;
    logic                              r_sticky, n_sticky;
    logic [rrd_pkg::CFG_DATA_W-1:0]    r_report_bytes;
    logic                              r_dedup_enable;
    logic [rrd_pkg::M_TDATA_W-1:0]     r_result;

    logic [IDX_W-1:0]                  wr_next, wr_prev, rd_next, rd_addr;
    logic [rrd_pkg::CFG_DATA_W-1:0]    n_bytes;
    logic [RW-1:0]                     mask;
    logic                              empty, full, dup, mem_we;
    logic                              res_stored, res_dup, res_dropped, res_resubmit;
    logic                              res_pop_valid, res_overflow;
    logic [rrd_pkg::REPORT_W-1:0]      res_report;
    logic [rrd_pkg::SERIAL_W-1:0]      res_serial;

    assign o_result = r_result;

    assign wr_next = (r_wr_idx == IDX_W'(RING_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
    assign wr_prev = (r_wr_idx == '0) ? IDX_W'(RING_DEPTH - 1) : r_wr_idx - 1'b1;
    assign rd_next = (r_rd_idx == IDX_W'(RING_DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
    // pop reads the oldest entry, push reads the newest for the duplicate check
    assign rd_addr = (i_func == rrd_pkg::FUNC_POP) ? r_rd_idx : wr_prev;

    // effective report size, clamped to 1..MAX_REPORT_BYTES
    always_comb begin
        n_bytes = r_report_bytes;
        if (n_bytes == '0) begin
            n_bytes = rrd_pkg::CFG_DATA_W'(1);
        end
        if (n_bytes > rrd_pkg::CFG_DATA_W'(MAX_REPORT_BYTES)) begin
            n_bytes = rrd_pkg::CFG_DATA_W'(MAX_REPORT_BYTES);
        end
        for (int b = 0; b < MAX_REPORT_BYTES; b++) begin
            mask[b*8 +: 8] = {8{rrd_pkg::CFG_DATA_W'(b) < n_bytes}};
        end
    end

    assign empty = (r_wr_idx == r_rd_idx);
    assign full  = (wr_next == r_rd_idx);
    assign dup   = !empty && r_dedup_enable && (((r_rd_report ^ r_data) & mask) == '0);

    always_comb begin
        n_wr_idx      = r_wr_idx;
        n_rd_idx      = r_rd_idx;
        n_serial      = r_serial;
        n_sticky      = r_sticky;
        mem_we        = 1'b0;
        res_stored    = 1'b0;
        res_dup       = 1'b0;
        res_dropped   = 1'b0;
        res_resubmit  = 1'b0;
        res_pop_valid = 1'b0;
        res_overflow  = 1'b0;
        res_report    = '0;
        res_serial    = '0;
        if (r_func == rrd_pkg::FUNC_PUSH) begin
            res_resubmit = (r_status != rrd_pkg::XFER_LINK_RESET);
            if (r_status == rrd_pkg::XFER_OK) begin
                if (dup) begin
                    res_dup = 1'b1;
                end else begin
                    if (full) begin
                        n_rd_idx    = rd_next;
                        n_sticky    = 1'b1;
                        res_dropped = 1'b1;
                    end
                    mem_we     = 1'b1;
                    res_stored = 1'b1;
                    n_serial   = r_serial + 1'b1;
                    n_wr_idx   = wr_next;
                end
            end
        end else begin
            res_overflow = r_sticky;
            if (!empty) begin
                res_pop_valid = 1'b1;
                res_report    = rrd_pkg::REPORT_W'(r_rd_report);
                res_serial    = r_rd_serial;
                n_rd_idx      = rd_next;
                n_sticky      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_idx       <= '0;
            r_rd_idx       <= '0;
            r_serial       <= '0;
            r_sticky       <= 1'b0;
            r_report_bytes <= rrd_pkg::CFG_DATA_W'(8);
            r_dedup_enable <= 1'b1;
        end else begin
            if (i_cmd.commit) begin
                r_wr_idx <= n_wr_idx;
                r_rd_idx <= n_rd_idx;
                r_serial <= n_serial;
                r_sticky <= n_sticky;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    rrd_pkg::CFG_REPORT_BYTES: r_report_bytes <= i_cfg_data;
                    rrd_pkg::CFG_DEDUP_ENABLE: r_dedup_enable <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // item latch, ring memories and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func      <= i_func;
            r_status    <= i_status;
            r_data      <= i_data[RW-1:0];
            r_rd_report <= r_report_mem[rd_addr];
            r_rd_serial <= r_serial_mem[rd_addr];
        end
        if (i_cmd.commit && mem_we) begin
            r_report_mem[r_wr_idx] <= r_data & mask;
            r_serial_mem[r_wr_idx] <= r_serial;
        end
        if (i_cmd.commit) begin
            r_result <= {2'b00, res_overflow, res_serial, res_report, res_pop_valid,
                         res_resubmit, res_dropped, res_dup, res_stored};
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rrd_checker.sv */
// Port-level checks of report_ring_with_dedup_unit, bound to the top level.
// Depends on rrd_pkg and report_ring_with_dedup_unit_defines.svh.
`default_nettype none
`include "report_ring_with_dedup_unit_defines.svh"

module rrd_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [rrd_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    logic res_stored, res_dup, res_dropped, res_resubmit, res_pop_valid;

    assign res_stored    = m_axis_tdata[0];
    assign res_dup       = m_axis_tdata[1];
    assign res_dropped   = m_axis_tdata[2];
    assign res_resubmit  = m_axis_tdata[3];
    assign res_pop_valid = m_axis_tdata[4];

    // one operation in flight: input closes right after a transfer
    `RRD_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a pop result carries no push flags
    `RRD_ASSERT_NOW(a_pop_clean, i_clk, i_rst_n, m_axis_tvalid && res_pop_valid, !res_stored && !res_dup && !res_dropped && !res_resubmit)

    // push outcome: a drop only with a store, a store or duplicate rearms
    `RRD_ASSERT_NOW(a_push_flags, i_clk, i_rst_n, m_axis_tvalid && (res_stored || res_dup || res_dropped), !(res_stored && res_dup) && (!res_dropped || res_stored) && res_resubmit)

    // stalled result holds
    `RRD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind report_ring_with_dedup_unit rrd_checker u_rrd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

/* verif/report_ring_with_dedup_unit_tb.sv */
// Self-checking bench for report_ring_with_dedup_unit: a directed table, then random
// pushes and pops under several size and dedup settings. Every result is scored against
// its table entry or a local ring predictor. Depends on rrd_pkg and the top level RTL.
`timescale 1ns / 1ps

module report_ring_with_dedup_unit_tb;
    import rrd_pkg::*;

    localparam int DEPTH = RING_DEPTH_DEF;
    localparam int MAXB  = MAX_REPORT_BYTES_DEF;

    // status codes the package leaves unnamed
    localparam logic [STATUS_W-1:0] XFER_ERROR    = 2'd2;
    localparam logic [STATUS_W-1:0] XFER_RESERVED = 2'd3;
    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    // result flags {pop_valid, resubmit, dropped_oldest, duplicate, stored}
    localparam logic [4:0] FL_NONE    = 5'b00000;
    localparam logic [4:0] FL_DISCARD = 5'b01000;
    localparam logic [4:0] FL_STORED  = 5'b01001;
    localparam logic [4:0] FL_DUP     = 5'b01010;
    localparam logic [4:0] FL_POPPED  = 5'b10000;

    typedef struct packed {
        logic [M_TDATA_W-78-1:0] pad;
        logic                    overflow_seen;
        logic [SERIAL_W-1:0]     out_serial;
        logic [REPORT_W-1:0]     out_report;
        logic                    pop_valid;
        logic                    resubmit;
        logic                    dropped_oldest;
        logic                    duplicate;
        logic                    stored;
    } ring_result_t;

    typedef struct {
        logic                op;
        logic [STATUS_W-1:0] status;
        logic [REPORT_W-1:0] data;
        bit                  typed;
        ring_result_t        want;
    } dir_row_t;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [S_TDATA_W-1:0]   s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_axis_tdata;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;

    // predictor state
    logic [REPORT_W-1:0] model_reports [DEPTH];
    logic [SERIAL_W-1:0] model_serials [DEPTH];
    int                  wr_ptr = 0;
    int                  rd_ptr = 0;
    logic [SERIAL_W-1:0] serial_next = '0;
    logic                ovf_flag = 1'b0;
    logic [3:0]          cfg_bytes = 4'd8;
    logic                dedup_on = 1'b1;

    ring_result_t        pending_results[$];
    dir_row_t            dir_rows[$];
    logic [REPORT_W-1:0] last_pushed = '0;
    int                  src_idle_pct = 0;
    int                  snk_idle_pct = 0;
    int                  bad_results = 0;

    report_ring_with_dedup_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [REPORT_W-1:0] size_mask();
        int n;
        n = cfg_bytes;
        if (n < 1) n = 1;
        if (n > MAXB) n = MAXB;
        if (n >= 8) return '1;
        return (64'd1 << (n * 8)) - 64'd1;
    endfunction

    function automatic ring_result_t mk_result(logic [4:0] flags, logic [REPORT_W-1:0] rpt,
                                               logic [SERIAL_W-1:0] ser, logic ovf);
        ring_result_t r;
        r = '0;
        {r.pop_valid, r.resubmit, r.dropped_oldest, r.duplicate, r.stored} = flags;
        r.out_report    = rpt;
        r.out_serial    = ser;
        r.overflow_seen = ovf;
        return r;
    endfunction

    // Advances the ring state by one operation and returns its result.
    function automatic ring_result_t ring_outcome(logic op, logic [STATUS_W-1:0] status,
                                                  logic [REPORT_W-1:0] data);
        ring_result_t        r;
        logic [REPORT_W-1:0] mask;
        int                  newest;
        r    = '0;
        mask = size_mask();
        if (op == FUNC_PUSH) begin
            if (status == XFER_LINK_RESET) return r;
            r.resubmit = 1'b1;
            if (status != XFER_OK) return r;
            if (wr_ptr != rd_ptr && dedup_on) begin
                newest = (wr_ptr + DEPTH - 1) % DEPTH;
                if (((model_reports[newest] ^ data) & mask) == '0) begin
                    r.duplicate = 1'b1;
                    return r;
                end
            end
            // full ring: one slot always stays free
            if ((wr_ptr + 1) % DEPTH == rd_ptr) begin
                rd_ptr           = (rd_ptr + 1) % DEPTH;
                ovf_flag         = 1'b1;
                r.dropped_oldest = 1'b1;
            end
            model_reports[wr_ptr] = data & mask;
            model_serials[wr_ptr] = serial_next;
            serial_next           = serial_next + 1'b1;
            wr_ptr                = (wr_ptr + 1) % DEPTH;
            r.stored              = 1'b1;
        end else begin
            r.overflow_seen = ovf_flag;
            if (wr_ptr != rd_ptr) begin
                r.pop_valid  = 1'b1;
                r.out_report = model_reports[rd_ptr];
                r.out_serial = model_serials[rd_ptr];
                rd_ptr       = (rd_ptr + 1) % DEPTH;
                ovf_flag     = 1'b0;
            end
        end
        return r;
    endfunction

    task automatic add_row(logic op, logic [STATUS_W-1:0] status, logic [REPORT_W-1:0] data,
                           bit typed, ring_result_t want);
        dir_row_t row;
        row.op     = op;
        row.status = status;
        row.data   = data;
        row.typed  = typed;
        row.want   = want;
        dir_rows.push_back(row);
    endtask

    // Leaves tvalid high after the transfer; the caller lowers it.
    task automatic send_op(logic op, logic [STATUS_W-1:0] status, logic [REPORT_W-1:0] data,
                           bit typed, ring_result_t typed_want);
        ring_result_t r;
        while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(S_TDATA_W-REPORT_W-STATUS_W){1'b0}}, data, status};
        do @(posedge i_clk); while (!s_axis_tready);
        r = ring_outcome(op, status, data);
        pending_results.push_back(typed ? typed_want : r);
        if (op == FUNC_PUSH) last_pushed = data;
    endtask

    // Leaves cfg_valid high after the transfer; the caller lowers it.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!cfg_ready);
        case (idx)
            CFG_REPORT_BYTES: cfg_bytes = val;
            CFG_DEDUP_ENABLE: dedup_on  = val[0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Mostly clean pushes with data close to the last pushed report, so the
    // duplicate filter and the overflow path both get exercised.
    task automatic pick_op(int push_pct, output logic op, output logic [STATUS_W-1:0] status,
                           output logic [REPORT_W-1:0] data);
        int                  sel;
        logic [REPORT_W-1:0] mask;
        mask = size_mask();
        op   = ($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP;
        sel  = $urandom_range(99);
        if (sel < 80)      status = XFER_OK;
        else if (sel < 87) status = XFER_LINK_RESET;
        else if (sel < 94) status = XFER_ERROR;
        else               status = XFER_RESERVED;
        sel = $urandom_range(99);
        if (sel < 25)
            data = last_pushed;
        else if (sel < 45)
            data = (last_pushed & mask) | ({$urandom, $urandom} & ~mask);
        else if (sel < 55)
            data = {56'd0, 8'($urandom_range(3))};
        else
            data = {$urandom, $urandom};
    endtask

    // result side: random backpressure, score every transfer
    initial begin
        ring_result_t got;
        ring_result_t want;
        bit           bad;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                got = ring_result_t'(m_axis_tdata);
                if (pending_results.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("unexpected result transfer %h", got);
                end else begin
                    want = pending_results.pop_front();
                    bad  = got.stored !== want.stored || got.duplicate !== want.duplicate ||
                           got.dropped_oldest !== want.dropped_oldest ||
                           got.resubmit !== want.resubmit || got.pop_valid !== want.pop_valid ||
                           got.out_report !== want.out_report ||
                           got.out_serial !== want.out_serial ||
                           got.overflow_seen !== want.overflow_seen || got.pad !== want.pad;
                    if (bad) begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display("mismatch: exp flags=%b rpt=%h ser=%h ovf=%b pad=%b | got flags=%b rpt=%h ser=%h ovf=%b pad=%b",
                                     {want.pop_valid, want.resubmit, want.dropped_oldest,
                                      want.duplicate, want.stored}, want.out_report,
                                     want.out_serial, want.overflow_seen, want.pad,
                                     {got.pop_valid, got.resubmit, got.dropped_oldest,
                                      got.duplicate, got.stored}, got.out_report,
                                     got.out_serial, got.overflow_seen, got.pad);
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial begin
        int                  ph_bytes [7];
        logic [3:0]          ph_dedup [7];
        int                  ph_push  [7];
        int                  ph_src   [7];
        int                  ph_snk   [7];
        logic                op;
        logic [STATUS_W-1:0] status;
        logic [REPORT_W-1:0] data;
        ring_result_t        none;

        ph_bytes = '{8, 1, 0, 15, 3, 5, 8};
        ph_dedup = '{4'h1, 4'h1, 4'h1, 4'hE, 4'h1, 4'h0, 4'h1};
        ph_push  = '{60, 70, 50, 75, 40, 55, 60};
        ph_src   = '{37, 37, 37, 81, 81, 0, 0};
        ph_snk   = '{81, 81, 81, 37, 37, 0, 0};
        none = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, reset configuration: 8 bytes, dedup on
        add_row(FUNC_POP,  XFER_OK,         '0, 1, mk_result(FL_NONE, '0, '0, 1'b0));
        add_row(FUNC_PUSH, XFER_LINK_RESET, '1, 1, mk_result(FL_NONE, '0, '0, 1'b0));
        add_row(FUNC_PUSH, XFER_ERROR,      '1, 1, mk_result(FL_DISCARD, '0, '0, 1'b0));
        add_row(FUNC_PUSH, XFER_RESERVED,   '1, 1, mk_result(FL_DISCARD, '0, '0, 1'b0));
        add_row(FUNC_PUSH, XFER_OK,         '1, 1, mk_result(FL_STORED, '0, '0, 1'b0));
        add_row(FUNC_PUSH, XFER_OK,         '1, 1, mk_result(FL_DUP, '0, '0, 1'b0));
        add_row(FUNC_POP,  XFER_OK,         '0, 1, mk_result(FL_POPPED, '1, '0, 1'b0));
        // one push past capacity drops the oldest and sets the sticky flag
        for (int k = 0; k < DEPTH; k++)
            add_row(FUNC_PUSH, XFER_OK, {8{8'(k)}}, 0, none);
        add_row(FUNC_POP, XFER_OK, '0, 0, none);
        add_row(FUNC_POP, XFER_OK, '0, 0, none);

        src_idle_pct = 37;
        snk_idle_pct = 81;
        foreach (dir_rows[i])
            send_op(dir_rows[i].op, dir_rows[i].status, dir_rows[i].data,
                    dir_rows[i].typed, dir_rows[i].want);
        s_axis_tvalid <= 1'b0;

        for (int ph = 0; ph < 7; ph++) begin
            drain();
            cfg_write(CFG_REPORT_BYTES, 4'(ph_bytes[ph]));
            cfg_write(CFG_DEDUP_ENABLE, ph_dedup[ph]);
            if (ph == 6) cfg_write(CFG_SPARE, 4'hF);
            cfg_valid <= 1'b0;
            src_idle_pct = ph_src[ph];
            snk_idle_pct = ph_snk[ph];
            for (int i = 0; i < 70; i++) begin
                if (ph == 1 && i == 35) begin
                    // hold off until the output side has caught up
                    s_axis_tvalid <= 1'b0;
                    drain();
                end
                pick_op(ph_push[ph], op, status, data);
                send_op(op, status, data, 0, none);
            end
            s_axis_tvalid <= 1'b0;
        end

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (bad_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
